/* hdl/blup2x_pkg.sv */
// ----------------------------------------------------------------------------
// blup2x_pkg
// shared widths, register indexes and weight helper for the 2x upsampler
// ----------------------------------------------------------------------------
package blup2x_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned COORD_W     = 11;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned DEF_MAX_W   = 1024;
  localparam int unsigned DEF_MAX_H   = 1024;
  localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;
  localparam logic [PIX_W-1:0] SIGN_FLIP = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_SIGNED_PIXELS = 2'd2,
    REG_UNUSED        = 2'd3
  } cfg_reg_t;

  // weight in quarters of the current pixel for tap k of a row or column list
  function automatic logic [2:0] tap_weight(input logic first, input logic [1:0] k);
    logic [2:0] w;
    w = 3'd4;
    if (!first) begin
      unique case (k)
        2'd0:    w = 3'd1;
        2'd1:    w = 3'd3;
        default: w = 3'd4;
      endcase
    end
    return w;
  endfunction

endpackage

/* hdl/bilinear_upsample_2x_fixed_top.sv */
// ----------------------------------------------------------------------------
// bilinear_upsample_2x_fixed_top
// 2x half-pixel bilinear upsampler for one plane of 8-bit raster pixels
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------
//  in_     | in  | in_valid / in_stall  | in_pixel_in
//  out_    | out | out_valid / out_stall| out_pixel_out, out_row, out_col,
//          |     |                      | out_last_of_run
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
//  each input pixel yields 1 to 9 output beats, one per cycle on the single
//  output port, about 4 per pixel on average; the output port sets the rate
//  a pixel with a single result (top-left corner) leaves stage b as its beat
//  is loaded, so pixels can follow each other every cycle when results are
//  few and out_stall is low; an input beat passes stage a, stage b and the
//  output register; the row store has no clearing pass: it is ready right
//  after reset; out_stall holds the output register; the two work stages
//  behind it keep one pixel each, and in_stall rises once both are full
// ----------------------------------------------------------------------------
module bilinear_upsample_2x_fixed_top #(
  parameter int unsigned MAX_WIDTH  = blup2x_pkg::DEF_MAX_W,
  parameter int unsigned MAX_HEIGHT = blup2x_pkg::DEF_MAX_H
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [blup2x_pkg::PIX_W-1:0]     in_pixel_in,
  // result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [blup2x_pkg::PIX_W-1:0]     out_pixel_out,
  output logic [blup2x_pkg::COORD_W-1:0]   out_row,
  output logic [blup2x_pkg::COORD_W-1:0]   out_col,
  output logic                             out_last_of_run,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [blup2x_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blup2x_pkg::CFG_W-1:0]     cfg_wdata
);
  import blup2x_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);   // column counter / store index
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);  // row counter
  localparam int unsigned OCW = CW + 1;              // doubled column
  localparam int unsigned ORW = RW + 1;              // doubled row

  // clamp a written dimension and turn it into the index of the last pixel
  function automatic logic [CW-1:0] width_last(input logic [CFG_W-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    if (e == 32'd0) return '0;
    else if (e > MAX_WIDTH) return CW'(MAX_WIDTH - 1);
    else return CW'(e - 32'd1);
  endfunction

  function automatic logic [RW-1:0] height_last(input logic [CFG_W-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    if (e == 32'd0) return '0;
    else if (e > MAX_HEIGHT) return RW'(MAX_HEIGHT - 1);
    else return RW'(e - 32'd1);
  endfunction

  // --------------------------------------------------------------------------
  // configuration: kept already clamped, as last column / last row index
  // --------------------------------------------------------------------------
  logic [CW-1:0]    wlast_r;
  logic [RW-1:0]    hlast_r;
  logic [PIX_W-1:0] flip_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= width_last(DIM_RESET);
      hlast_r <= height_last(DIM_RESET);
      flip_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:   wlast_r <= width_last(cfg_wdata);
        REG_IMAGE_HEIGHT:  hlast_r <= height_last(cfg_wdata);
        REG_SIGNED_PIXELS: flip_r  <= cfg_wdata[0] ? SIGN_FLIP : '0;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake between stages
  // --------------------------------------------------------------------------
  logic a_valid_r, b_valid_r, out_valid_r;
  logic out_load, b_last, b_done, a_move, in_accept;

  assign out_load  = !out_valid_r || !out_stall;
  assign b_done    = b_valid_r && b_last && out_load;
  assign a_move    = a_valid_r && (!b_valid_r || b_done);
  assign in_stall  = a_valid_r && !a_move;
  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // raster position
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_cnt_r;
  logic [RW-1:0] row_cnt_r;
  logic          is_last_col, is_last_row;

  assign is_last_col = col_cnt_r >= wlast_r;
  assign is_last_row = row_cnt_r >= hlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_accept) begin
      if (is_last_col) begin
        col_cnt_r <= '0;
        row_cnt_r <= is_last_row ? '0 : row_cnt_r + RW'(1);
      end else begin
        col_cnt_r <= col_cnt_r + CW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // previous-row store: read old value and write new pixel at the same column
  // in the accept cycle; the read data sits with stage a
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] row_mem [MAX_WIDTH];
  logic [PIX_W-1:0] mem_q;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem_q              <= row_mem[col_cnt_r];
      row_mem[col_cnt_r] <= in_pixel_in;
    end
  end

  // --------------------------------------------------------------------------
  // stage a: pixel and position waiting for its upper neighbor
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] a_pix_r;
  logic [CW-1:0]    a_col_r;
  logic [RW-1:0]    a_row_r;
  logic             a_lc_r, a_lr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_accept) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_pix_r <= in_pixel_in;
      a_col_r <= col_cnt_r;
      a_row_r <= row_cnt_r;
      a_lc_r  <= is_last_col;
      a_lr_r  <= is_last_row;
    end
  end

  // sliding window: upper-left and left neighbors, updated in pixel order
  logic [PIX_W-1:0] ul_pix_r, left_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ul_pix_r   <= '0;
      left_pix_r <= '0;
    end else if (a_move) begin
      ul_pix_r   <= mem_q;
      left_pix_r <= a_pix_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage b: walks the 1..3 x 1..3 output grid, unless stalled one beat per cycle
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] b_a_r, b_b_r, b_cl_r, b_d_r;
  logic [CW-1:0]    b_col_r;
  logic [RW-1:0]    b_row_r;
  logic             b_lc_r, b_lr_r;
  logic [1:0]       ri_r, ci_r;
  logic [1:0]       ri_end, ci_end;
  logic             first_row, first_col;

  assign first_row = (b_row_r == '0);
  assign first_col = (b_col_r == '0);
  // index of the last tap in each list
  assign ri_end = (first_row ? 2'd0 : 2'd1) + {1'b0, b_lr_r};
  assign ci_end = (first_col ? 2'd0 : 2'd1) + {1'b0, b_lc_r};
  assign b_last = (ri_r == ri_end) && (ci_r == ci_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      ri_r      <= '0;
      ci_r      <= '0;
    end else if (a_move) begin
      b_valid_r <= 1'b1;
      ri_r      <= '0;
      ci_r      <= '0;
    end else if (b_valid_r && out_load) begin
      if (b_last) begin
        b_valid_r <= 1'b0;
      end else if (ci_r == ci_end) begin
        ci_r <= '0;
        ri_r <= ri_r + 2'd1;
      end else begin
        ci_r <= ci_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_a_r   <= ul_pix_r;
      b_b_r   <= mem_q;
      b_cl_r  <= left_pix_r;
      b_d_r   <= a_pix_r;
      b_col_r <= a_col_r;
      b_row_r <= a_row_r;
      b_lc_r  <= a_lc_r;
      b_lr_r  <= a_lr_r;
    end
  end

  // weighted sum of the biased window for the current tap pair
  logic [2:0]       wv, wh, wvn, whn;
  logic [4:0]       k_a, k_b, k_c, k_d;
  logic [PIX_W-1:0] op_a, op_b;
  logic [12:0]      acc;
  logic [PIX_W-1:0] px_nxt;
  logic [ORW-1:0]   orow_nxt;
  logic [OCW-1:0]   ocol_nxt;

  always_comb begin
    wv  = tap_weight(first_row, ri_r);
    wh  = tap_weight(first_col, ci_r);
    wvn = 3'd4 - wv;
    whn = 3'd4 - wh;
    k_a = 5'(6'(wvn) * 6'(whn));
    k_b = 5'(6'(wvn) * 6'(wh));
    k_c = 5'(6'(wv) * 6'(whn));
    k_d = 5'(6'(wv) * 6'(wh));
    // upper neighbors on the top row may come from never-written store entries;
    // a zero weight keeps them out of the sum entirely
    op_a = (k_a == 5'd0) ? '0 : (b_a_r ^ flip_r);
    op_b = (k_b == 5'd0) ? '0 : (b_b_r ^ flip_r);
    acc = 13'(k_a) * 13'(op_a) + 13'(k_b) * 13'(op_b)
        + 13'(k_c) * 13'(b_cl_r ^ flip_r) + 13'(k_d) * 13'(b_d_r ^ flip_r);
    px_nxt = acc[11:4] ^ flip_r;
    // doubled coordinates: first list starts at 0, else at 2n-1
    orow_nxt = first_row ? ORW'(ri_r) : ({b_row_r, 1'b0} + ORW'(ri_r) - ORW'(1));
    ocol_nxt = first_col ? OCW'(ci_r) : ({b_col_r, 1'b0} + OCW'(ci_r) - OCW'(1));
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0]   out_pix_r;
  logic [COORD_W-1:0] out_row_r, out_col_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && b_valid_r) begin
      out_pix_r  <= px_nxt;
      out_row_r  <= COORD_W'(orow_nxt);
      out_col_r  <= COORD_W'(ocol_nxt);
      out_last_r <= b_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = out_pix_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_last_of_run = out_last_r;

endmodule

/* hdl/blup2x_checker.sv */
// ----------------------------------------------------------------------------
// blup2x_checker
// port-level checks for the 2x upsampler, bound to the top level
// ----------------------------------------------------------------------------
module blup2x_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [blup2x_pkg::PIX_W-1:0]     in_pixel_in,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [blup2x_pkg::PIX_W-1:0]     out_pixel_out,
  input logic [blup2x_pkg::COORD_W-1:0]   out_row,
  input logic [blup2x_pkg::COORD_W-1:0]   out_col,
  input logic                             out_last_of_run
);
  import blup2x_pkg::*;

  logic out_fire;
  assign out_fire = out_valid && !out_stall;

  // reset empties the output register
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out) && $stable(out_row)
      && $stable(out_col) && $stable(out_last_of_run))
    else $error("stalled output beat changed");

  // stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_pixel_in))
    else $error("stalled input beat changed");

  // beats of one run follow without a gap
  a_run_packed: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_last_of_run |=> out_valid)
    else $error("bubble inside a run of results");

  // inside a run rows stay or step by one
  a_run_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_last_of_run |=>
      out_row == $past(out_row) || out_row == COORD_W'($past(out_row) + 11'd1))
    else $error("row jump inside a run");

endmodule

bind bilinear_upsample_2x_fixed_top blup2x_checker u_blup2x_checker (.*);

/* tb/tb_bilinear_upsample_2x_fixed_top.sv */
// ----------------------------------------------------------------------------
// tb_bilinear_upsample_2x_fixed_top
// feeds raster pixels to the 2x bilinear upsampler and compares every output
// beat against a cycle-free predictor of the interpolation, the edge and
// corner rules, and the register handling; a directed table runs first, then
// random planes under three idle patterns, then a short plane whose width and
// height are written past the maximum
// ----------------------------------------------------------------------------
module tb_bilinear_upsample_2x_fixed_top;
  import blup2x_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;   // settle wait after the last expected beat
  localparam int unsigned STIM_ROWS     = 28;

  // one output beat as the block presents it
  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } upsample_beat_t;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

  // directed row: a pixel beat or a register write, with an optional
  // hand-written expectation for pixels that cause a single beat
  typedef struct packed {
    step_kind_t     kind;
    cfg_reg_t       reg_idx;
    logic [CFG_W-1:0] value;
    logic           typed;
    upsample_beat_t beat;
  } stim_row_t;

  // clock and block inputs, all known from time zero
  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic [PIX_W-1:0]     in_pixel_in = '0;
  logic                 out_stall   = 1'b0;
  logic                 cfg_valid   = 1'b0;
  cfg_reg_t             cfg_index   = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata   = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic [PIX_W-1:0]     out_pixel_out;
  logic [COORD_W-1:0]   out_row;
  logic [COORD_W-1:0]   out_col;
  logic                 out_last_of_run;
  logic                 cfg_ready;

  // predictor state: line buffer, neighbor pixels, raster position, registers
  logic [PIX_W-1:0]     line_mem [DEF_MAX_W] = '{default: '0};
  logic [PIX_W-1:0]     upper_left  = '0;
  logic [PIX_W-1:0]     left_pix    = '0;
  int unsigned          col_cnt     = 0;
  int unsigned          row_cnt     = 0;
  int unsigned          line_written = 0;   // entries 0..line_written-1 hold data
  logic [CFG_W-1:0]     width_reg   = DIM_RESET;
  logic [CFG_W-1:0]     height_reg  = DIM_RESET;
  logic                 signed_reg  = 1'b0;

  upsample_beat_t       pending_upsampled [$];
  int unsigned          mismatch_count = 0;

  // idle percentages of the current phase
  int unsigned          gap_pct   = 0;
  int unsigned          stall_pct = 0;

  stim_row_t stim_table [STIM_ROWS] = '{
    // reset setting, 1024 wide: top-left corner is a plain copy
    '{STEP_PIXEL, REG_UNUSED,        11'h0A5, 1'b1, '{8'hA5, 11'd0, 11'd0, 1'b1}},
    '{STEP_PIXEL, REG_UNUSED,        11'h000, 1'b0, '0},
    // shrink width and zero height mid-row: the next pixel closes the plane
    '{STEP_WRITE, REG_IMAGE_WIDTH,   11'd3,   1'b0, '0},
    '{STEP_WRITE, REG_IMAGE_HEIGHT,  11'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_UNUSED,        11'h0FF, 1'b0, '0},
    // signed 2x2 plane swinging between the two extremes
    '{STEP_WRITE, REG_SIGNED_PIXELS, 11'd1,   1'b0, '0},
    '{STEP_WRITE, REG_IMAGE_WIDTH,   11'd2,   1'b0, '0},
    '{STEP_WRITE, REG_IMAGE_HEIGHT,  11'd2,   1'b0, '0},
    '{STEP_PIXEL, REG_UNUSED,        11'h080, 1'b1, '{8'h80, 11'd0, 11'd0, 1'b1}},
    '{STEP_PIXEL, REG_UNUSED,        11'h07F, 1'b0, '0},
    '{STEP_PIXEL, REG_UNUSED,        11'h07F, 1'b0, '0},
    '{STEP_PIXEL, REG_UNUSED,        11'h080, 1'b0, '0},
    // -1 next to 0: half-way values must floor toward minus infinity
    '{STEP_PIXEL, REG_UNUSED,        11'h0FF, 1'b1, '{8'hFF, 11'd0, 11'd0, 1'b1}},
    '{STEP_PIXEL, REG_UNUSED,        11'h000, 1'b0, '0},
    '{STEP_PIXEL, REG_UNUSED,        11'h000, 1'b0, '0},
    '{STEP_PIXEL, REG_UNUSED,        11'h0FF, 1'b0, '0},
    // index past the register list is ignored
    '{STEP_WRITE, REG_UNUSED,        11'h7FF, 1'b0, '0},
    // unsigned single-pixel plane, zero width read as one: four copies each
    '{STEP_WRITE, REG_SIGNED_PIXELS, 11'd0,   1'b0, '0},
    '{STEP_WRITE, REG_IMAGE_WIDTH,   11'd0,   1'b0, '0},
    '{STEP_WRITE, REG_IMAGE_HEIGHT,  11'd1,   1'b0, '0},
    '{STEP_PIXEL, REG_UNUSED,        11'h0FF, 1'b0, '0},
    '{STEP_PIXEL, REG_UNUSED,        11'h000, 1'b0, '0},
    // unsigned 2x2 checkerboard
    '{STEP_WRITE, REG_IMAGE_WIDTH,   11'd2,   1'b0, '0},
    '{STEP_WRITE, REG_IMAGE_HEIGHT,  11'd2,   1'b0, '0},
    '{STEP_PIXEL, REG_UNUSED,        11'h000, 1'b0, '0},
    '{STEP_PIXEL, REG_UNUSED,        11'h0FF, 1'b0, '0},
    '{STEP_PIXEL, REG_UNUSED,        11'h0FF, 1'b0, '0},
    '{STEP_PIXEL, REG_UNUSED,        11'h000, 1'b0, '0}
  };

  bilinear_upsample_2x_fixed_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_in     (in_pixel_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // zero reads as one, anything past the maximum saturates
  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // expected beats for one accepted pixel; advances the predictor state
  function automatic void upsample_pixel(input logic [PIX_W-1:0] px,
                                         ref upsample_beat_t beats[$]);
    int unsigned w, h, c, r, nr, nc, wv, wh, acc, i, j;
    int unsigned row_at [3];
    int unsigned row_wt [3];
    int unsigned col_at [3];
    int unsigned col_wt [3];
    logic [PIX_W-1:0] flip, above, a, b, cl, d;
    logic last_col, last_row;
    upsample_beat_t beat;
    w = eff_dim(width_reg, DEF_MAX_W);
    h = eff_dim(height_reg, DEF_MAX_H);
    flip = signed_reg ? SIGN_FLIP : '0;
    c = col_cnt % DEF_MAX_W;
    r = row_cnt;
    last_col = (c >= w - 1);
    last_row = (r >= h - 1);
    above = line_mem[c];
    // sign bit flipped turns two's complement into an offset code, exact for floor
    a  = upper_left ^ flip;
    b  = above ^ flip;
    cl = left_pix ^ flip;
    d  = px ^ flip;

    // taps in quarters of the current pixel: 1/4 then 3/4, or 4/4 on an edge
    nr = 0;
    if (r == 0) begin
      row_at[0] = 0; row_wt[0] = 4; nr = 1;
    end else begin
      row_at[0] = 2 * r - 1; row_wt[0] = 1;
      row_at[1] = 2 * r;     row_wt[1] = 3; nr = 2;
    end
    if (last_row) begin
      row_at[nr] = 2 * r + 1; row_wt[nr] = 4; nr++;
    end
    nc = 0;
    if (c == 0) begin
      col_at[0] = 0; col_wt[0] = 4; nc = 1;
    end else begin
      col_at[0] = 2 * c - 1; col_wt[0] = 1;
      col_at[1] = 2 * c;     col_wt[1] = 3; nc = 2;
    end
    if (last_col) begin
      col_at[nc] = 2 * c + 1; col_wt[nc] = 4; nc++;
    end

    for (i = 0; i < nr; i++) begin
      for (j = 0; j < nc; j++) begin
        wv = row_wt[i];
        wh = col_wt[j];
        acc = (4 - wv) * (4 - wh) * a + (4 - wv) * wh * b
            + wv * (4 - wh) * cl + wv * wh * d;
        beat.pix  = 8'(acc >> 4) ^ flip;
        beat.row  = 11'(row_at[i]);
        beat.col  = 11'(col_at[j]);
        beat.last = (i == nr - 1) && (j == nc - 1);
        beats.push_back(beat);
      end
    end

    upper_left = above;
    left_pix   = px;
    line_mem[c] = px;
    if (c + 1 > line_written) line_written = c + 1;
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // extremes and the sign boundary turn up often
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one input beat, with random idle cycles ahead of it; entered just after an edge
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic typed = 1'b0,
                            input upsample_beat_t typed_beat = '0);
    upsample_beat_t beats [$];
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    do @(posedge clk); while (in_stall);
    upsample_pixel(px, beats);
    if (typed) pending_upsampled.push_back(typed_beat);
    else pending_upsampled = {pending_upsampled, beats};
  endtask

  // register write beat; only issued while the block is idle
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:   width_reg  = val;
      REG_IMAGE_HEIGHT:  height_reg = val;
      REG_SIGNED_PIXELS: signed_reg = val[0];
      default: ;
    endcase
  endtask

  // sender pauses until every expected beat is out, then lets the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_upsampled.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // finish a plane left open: a 1x1 setting makes the next pixel the last one
  task automatic close_plane();
    if (row_cnt != 0 || col_cnt != 0) begin
      write_reg(REG_IMAGE_WIDTH, 11'd1);
      write_reg(REG_IMAGE_HEIGHT, 11'd1);
      send_pixel(pick_pixel());
      wait_drained();
    end
  endtask

  // mostly whole small planes with random content, some register noise mid-plane
  task automatic random_phase(input int unsigned quota);
    int unsigned sent, w, h, n, k;
    cfg_reg_t idx;
    logic [CFG_W-1:0] val;
    sent = 0;
    while (sent < quota) begin
      wait_drained();
      if ($urandom_range(3) != 0) begin
        close_plane();
        w = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        h = (w > 8) ? $urandom_range(1, 3) : $urandom_range(1, 5);
        write_reg(REG_IMAGE_WIDTH, (w == 1 && $urandom_range(1)) ? 11'd0 : 11'(w));
        write_reg(REG_IMAGE_HEIGHT, (h == 1 && $urandom_range(1)) ? 11'd0 : 11'(h));
        write_reg(REG_SIGNED_PIXELS, 11'($urandom_range(2047)));
        for (k = 0; k < w * h; k++) send_pixel(pick_pixel());
        sent += w * h;
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          idx = cfg_reg_t'($urandom_range(3));
          case ($urandom_range(5))
            0:       val = 11'h7FF;
            1:       val = 11'd1024;
            2:       val = 11'd0;
            default: val = 11'($urandom_range(1, 12));
          endcase
          // widening past the filled part of the line buffer is only safe on the top row
          if (idx == REG_IMAGE_WIDTH && row_cnt != 0 && eff_dim(val, DEF_MAX_W) > line_written)
            val = 11'($urandom_range(1, line_written));
          write_reg(idx, val);
        end
        n = $urandom_range(1, 10);
        repeat (n) send_pixel(pick_pixel());
        sent += n;
      end
    end
  endtask

  // receiver stalls at the phase rate, never during reset
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // every accepted output beat against the oldest expectation
  always @(posedge clk) begin : check_beats
    upsample_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_upsampled.size() == 0) begin
        $display("%0t: beat with nothing expected: pixel %0d row %0d col %0d last %0d",
                 $time, out_pixel_out, out_row, out_col, out_last_of_run);
        mismatch_count++;
      end else begin
        want = pending_upsampled.pop_front();
        if (out_pixel_out !== want.pix) begin
          $display("%0t: pixel_out expected %0d got %0d (row %0d col %0d)",
                   $time, want.pix, out_pixel_out, want.row, want.col);
          mismatch_count++;
        end
        if (out_row !== want.row) begin
          $display("%0t: out_row expected %0d got %0d", $time, want.row, out_row);
          mismatch_count++;
        end
        if (out_col !== want.col) begin
          $display("%0t: out_col expected %0d got %0d", $time, want.col, out_col);
          mismatch_count++;
        end
        if (out_last_of_run !== want.last) begin
          $display("%0t: last_of_run expected %0d got %0d (row %0d col %0d)",
                   $time, want.last, out_last_of_run, want.row, want.col);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    // first phase: sender idles lightly, receiver stalls hard
    gap_pct   = 38;
    stall_pct = 86;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; writes wait for an idle block
    foreach (stim_table[s]) begin
      if (stim_table[s].kind == STEP_WRITE) begin
        wait_drained();
        write_reg(stim_table[s].reg_idx, stim_table[s].value);
      end else begin
        send_pixel(stim_table[s].value[PIX_W-1:0], stim_table[s].typed, stim_table[s].beat);
      end
    end

    random_phase(75);

    // second phase: the other way round
    wait_drained();
    gap_pct   = 86;
    stall_pct = 38;
    random_phase(75);

    // third phase: no idling at all
    wait_drained();
    gap_pct   = 0;
    stall_pct = 0;
    random_phase(70);

    // width and height written past the maximum saturate; a few top-row pixels
    wait_drained();
    close_plane();
    write_reg(REG_IMAGE_WIDTH, 11'h7FF);
    write_reg(REG_IMAGE_HEIGHT, 11'h7FF);
    repeat (8) send_pixel(pick_pixel());
    wait_drained();
    close_plane();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* bilinear_upsample_2x_fixed_top.f */
hdl/blup2x_pkg.sv
hdl/bilinear_upsample_2x_fixed_top.sv
hdl/blup2x_checker.sv
tb/tb_bilinear_upsample_2x_fixed_top.sv
